// ===== src/ccc_pkg.sv =====
`default_nettype none

package ccc_pkg;

  // Word format of every port field: signed Q16.16, angles as binary angles.
  localparam int WORD_BITS    = 32;
  localparam int PRESHIFT     = 24;
  localparam int CORDIC_STEPS = 32;
  // Internal CORDIC datapath width: 2^31 scaled by 2^24 plus gain and sign.
  localparam int CW           = 60;
  // Angle accumulator width: room for two full turns either way.
  localparam int AW           = 34;
  localparam int ROUND_BITS   = 30;
  localparam int SAT_W        = 72;

  localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;
  localparam logic signed [AW-1:0] QUARTER_TURN = 34'sh0_4000_0000;

  localparam logic signed [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Arctangent of 2^-i in binary-angle units.
  localparam logic [31:0] ANGTAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Pipeline depths in clock edges from the stage input to the result register.
  localparam int POLAR_LAT  = 2 + WORD_BITS + (WORD_BITS - 1) + 1;
  localparam int CORDIC_LAT = 1 + CORDIC_STEPS + 2;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] vel_x;
    logic signed [WORD_BITS-1:0] vel_y;
    logic signed [WORD_BITS-1:0] angle;
  } cordic_res_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] radius;
    logic signed [WORD_BITS-1:0] vel_r;
    logic signed [WORD_BITS-1:0] vel_t;
    logic                        r_zero;
  } polar_res_t;

  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic signed [WORD_BITS-1:0] res;
    if (v > SAT_W'(SMAX)) begin
      res = SMAX;
    end else if (v < SAT_W'(SMIN)) begin
      res = SMIN;
    end else begin
      res = v[WORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/ccc_cordic.sv =====
`default_nettype none

module ccc_cordic
  import ccc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic                        in_rot,
  input  wire logic signed [WORD_BITS-1:0] in_p1,
  input  wire logic signed [WORD_BITS-1:0] in_p2,
  input  wire logic signed [WORD_BITS-1:0] in_v1,
  input  wire logic signed [WORD_BITS-1:0] in_v2,
  output cordic_res_t                      out_res
);

  localparam int RW = CW - PRESHIFT;
  localparam int MW = RW + 32;
  localparam logic signed [CW-1:0] RND_PRE  = CW'(1) <<< (PRESHIFT - 1);
  localparam logic signed [MW-1:0] RND_GAIN = MW'(1) <<< (ROUND_BITS - 1);

  function automatic logic signed [MW-1:0] gain_mul(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [RW-1:0] w;
    t = v + RND_PRE;
    w = t[CW-1:PRESHIFT];
    return w * $signed(GAIN_Q30);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] gain_out(input logic signed [MW-1:0] m);
    logic signed [MW-1:0] t;
    t = (m + RND_GAIN) >>> ROUND_BITS;
    return sat_word(SAT_W'(t));
  endfunction

  logic                 vld_r [CORDIC_STEPS+1];
  logic                 rot_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] x_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0] u_r   [CORDIC_STEPS+1];
  logic signed [CW-1:0] w_r   [CORDIC_STEPS+1];
  logic signed [AW-1:0] ang_r [CORDIC_STEPS+1];

  logic signed [CW-1:0] sp1, sp2, sv1, sv2;
  logic signed [CW-1:0] x0, y0, u0, w0;
  logic signed [AW-1:0] a_in, a0;

  // Quadrant pre-rotation so that the iterations only cover +/- a quarter turn.
  always_comb begin
    sp1  = CW'(in_p1) <<< PRESHIFT;
    sp2  = CW'(in_p2) <<< PRESHIFT;
    sv1  = CW'(in_v1) <<< PRESHIFT;
    sv2  = CW'(in_v2) <<< PRESHIFT;
    a_in = AW'(in_p2);
    if (in_rot) begin
      x0 = sp1;
      y0 = '0;
      u0 = sv1;
      w0 = sv2;
      a0 = a_in;
      if (a_in > QUARTER_TURN) begin
        x0 = '0;
        y0 = sp1;
        u0 = -sv2;
        w0 = sv1;
        a0 = a_in - QUARTER_TURN;
      end else if (a_in < -QUARTER_TURN) begin
        x0 = '0;
        y0 = -sp1;
        u0 = sv2;
        w0 = -sv1;
        a0 = a_in + QUARTER_TURN;
      end
    end else begin
      x0 = sp1;
      y0 = sp2;
      u0 = '0;
      w0 = '0;
      a0 = '0;
      if (sp1 < 0) begin
        if (sp2 >= 0) begin
          x0 = sp2;
          y0 = -sp1;
          a0 = QUARTER_TURN;
        end else begin
          x0 = -sp2;
          y0 = sp1;
          a0 = -QUARTER_TURN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      rot_r[0] <= in_rot;
      x_r[0]   <= x0;
      y_r[0]   <= y0;
      u_r[0]   <= u0;
      w_r[0]   <= w0;
      ang_r[0] <= a0;
    end
  end

  // One micro-rotation per stage. Vectoring drives y toward zero, rotation
  // drives the residual angle toward zero; both share the same adders.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    logic                 ccw;
    logic signed [AW-1:0] step;

    assign ccw  = rot_r[k] ? ~ang_r[k][AW-1] : (y_r[k] <= 0);
    assign step = $signed(AW'(ANGTAB[k]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (vld_r[k]) begin
        rot_r[k+1] <= rot_r[k];
        if (ccw) begin
          x_r[k+1]   <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1]   <= y_r[k] + (x_r[k] >>> k);
          u_r[k+1]   <= u_r[k] - (w_r[k] >>> k);
          w_r[k+1]   <= w_r[k] + (u_r[k] >>> k);
          ang_r[k+1] <= ang_r[k] - step;
        end else begin
          x_r[k+1]   <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1]   <= y_r[k] - (x_r[k] >>> k);
          u_r[k+1]   <= u_r[k] + (w_r[k] >>> k);
          w_r[k+1]   <= w_r[k] - (u_r[k] >>> k);
          ang_r[k+1] <= ang_r[k] + step;
        end
      end
    end
  end

  logic                        m_vld_r;
  logic signed [MW-1:0]        m_r [4];
  logic signed [WORD_BITS-1:0] m_ang_r;
  cordic_res_t                 res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= vld_r[CORDIC_STEPS];
    end
  end

  // Gain compensation: round to Q16.16, multiply, then round and saturate.
  always_ff @(posedge clk) begin
    if (vld_r[CORDIC_STEPS]) begin
      m_r[0]  <= gain_mul(x_r[CORDIC_STEPS]);
      m_r[1]  <= gain_mul(y_r[CORDIC_STEPS]);
      m_r[2]  <= gain_mul(u_r[CORDIC_STEPS]);
      m_r[3]  <= gain_mul(w_r[CORDIC_STEPS]);
      m_ang_r <= ang_r[CORDIC_STEPS][WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (m_vld_r) begin
      res_r.pos_x <= gain_out(m_r[0]);
      res_r.pos_y <= gain_out(m_r[1]);
      res_r.vel_x <= gain_out(m_r[2]);
      res_r.vel_y <= gain_out(m_r[3]);
      res_r.angle <= m_ang_r;
    end
  end

  assign out_res = res_r;

endmodule

`default_nettype wire

// ===== src/ccc_polar.sv =====
`default_nettype none

module ccc_polar
  import ccc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic signed [WORD_BITS-1:0] in_p1,
  input  wire logic signed [WORD_BITS-1:0] in_p2,
  input  wire logic signed [WORD_BITS-1:0] in_v1,
  input  wire logic signed [WORD_BITS-1:0] in_v2,
  output logic                             out_vld,
  output polar_res_t                       out_res
);

  localparam int W    = WORD_BITS;
  localparam int W2   = 2 * WORD_BITS;
  localparam int SQ_N = WORD_BITS;
  localparam int DV_N = WORD_BITS - 1;

  typedef struct packed {
    logic                neg_a;
    logic                neg_b;
    logic signed [W-1:0] v1;
    logic signed [W-1:0] v2;
  } side_t;

  function automatic logic signed [W-1:0] apply_sign(input logic neg, input logic ovf,
                                                     input logic [DV_N-1:0] q);
    logic signed [W-1:0] m;
    logic signed [W-1:0] res;
    m = $signed({1'b0, q});
    if (ovf) begin
      res = neg ? SMIN : SMAX;
    end else begin
      res = neg ? -m : m;
    end
    return res;
  endfunction

  // Stage 1: squares and the four cross products.
  logic [W-1:0] ax, ay;
  assign ax = in_p1[W-1] ? $unsigned(-in_p1) : $unsigned(in_p1);
  assign ay = in_p2[W-1] ? $unsigned(-in_p2) : $unsigned(in_p2);

  logic                 s1_vld_r;
  logic [W2-1:0]        s1_sqx_r, s1_sqy_r;
  logic signed [W2-1:0] s1_m11_r, s1_m22_r, s1_m12_r, s1_m21_r;
  logic signed [W-1:0]  s1_v1_r, s1_v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      s1_sqx_r <= ax * ax;
      s1_sqy_r <= ay * ay;
      s1_m11_r <= in_p1 * in_v1;
      s1_m22_r <= in_p2 * in_v2;
      s1_m12_r <= in_p1 * in_v2;
      s1_m21_r <= in_p2 * in_v1;
      s1_v1_r  <= in_v1;
      s1_v2_r  <= in_v2;
    end
  end

  // Stage 2: sum of squares, dot and cross sums split into sign and magnitude.
  logic signed [W2:0] dot, crs;
  assign dot = (W2+1)'(s1_m11_r) + (W2+1)'(s1_m22_r);
  assign crs = (W2+1)'(s1_m12_r) - (W2+1)'(s1_m21_r);

  logic          s2_vld_r;
  logic [W2-1:0] s2_n_r, s2_ma_r, s2_mb_r;
  side_t         s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_n_r          <= s1_sqx_r + s1_sqy_r;
      s2_ma_r         <= dot[W2] ? W2'(-dot) : W2'(dot);
      s2_mb_r         <= crs[W2] ? W2'(-crs) : W2'(crs);
      s2_side_r.neg_a <= dot[W2];
      s2_side_r.neg_b <= crs[W2];
      s2_side_r.v1    <= s1_v1_r;
      s2_side_r.v2    <= s1_v2_r;
    end
  end

  // Square root, one result bit per stage, most significant first.
  logic          sq_vld_r  [SQ_N];
  logic [W2-1:0] sq_rem_r  [SQ_N];
  logic [W-1:0]  sq_root_r [SQ_N];
  logic [W2-1:0] sq_ma_r   [SQ_N];
  logic [W2-1:0] sq_mb_r   [SQ_N];
  side_t         sq_side_r [SQ_N];

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    localparam int J = SQ_N - 1 - i;
    logic          src_vld;
    logic [W2-1:0] src_rem, src_ma, src_mb;
    logic [W-1:0]  src_root;
    side_t         src_side;
    logic [W2+1:0] trial;

    if (i == 0) begin : g_first
      assign src_vld  = s2_vld_r;
      assign src_rem  = s2_n_r;
      assign src_root = '0;
      assign src_ma   = s2_ma_r;
      assign src_mb   = s2_mb_r;
      assign src_side = s2_side_r;
    end else begin : g_next
      assign src_vld  = sq_vld_r[i-1];
      assign src_rem  = sq_rem_r[i-1];
      assign src_root = sq_root_r[i-1];
      assign src_ma   = sq_ma_r[i-1];
      assign src_mb   = sq_mb_r[i-1];
      assign src_side = sq_side_r[i-1];
    end

    assign trial = ((W2+2)'(src_root) << (J + 1)) | ((W2+2)'(1) << (2 * J));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i] <= 1'b0;
      end else begin
        sq_vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (src_vld) begin
        if ((W2+2)'(src_rem) >= trial) begin
          sq_rem_r[i]  <= src_rem - trial[W2-1:0];
          sq_root_r[i] <= src_root | (W'(1) << J);
        end else begin
          sq_rem_r[i]  <= src_rem;
          sq_root_r[i] <= src_root;
        end
        sq_ma_r[i]   <= src_ma;
        sq_mb_r[i]   <= src_mb;
        sq_side_r[i] <= src_side;
      end
    end
  end

  // Two restoring dividers by the radius, one quotient bit per stage. The
  // first stage also flags a quotient that does not fit the word.
  logic            dv_vld_r  [DV_N];
  logic [W-1:0]    dv_r_r    [DV_N];
  logic [W2-1:0]   dv_ra_r   [DV_N];
  logic [W2-1:0]   dv_rb_r   [DV_N];
  logic [DV_N-1:0] dv_qa_r   [DV_N];
  logic [DV_N-1:0] dv_qb_r   [DV_N];
  logic            dv_oa_r   [DV_N];
  logic            dv_ob_r   [DV_N];
  logic            dv_zero_r [DV_N];
  side_t           dv_side_r [DV_N];

  for (genvar i = 0; i < DV_N; i++) begin : g_div
    localparam int B = DV_N - 1 - i;
    logic            src_vld, src_oa, src_ob, src_zero;
    logic [W-1:0]    src_r;
    logic [W2-1:0]   src_ra, src_rb, dsr;
    logic [DV_N-1:0] src_qa, src_qb;
    side_t           src_side;

    if (i == 0) begin : g_first
      assign src_vld  = sq_vld_r[SQ_N-1];
      assign src_r    = sq_root_r[SQ_N-1];
      assign src_ra   = sq_ma_r[SQ_N-1];
      assign src_rb   = sq_mb_r[SQ_N-1];
      assign src_qa   = '0;
      assign src_qb   = '0;
      assign src_oa   = (sq_ma_r[SQ_N-1] >> DV_N) >= W2'(sq_root_r[SQ_N-1]);
      assign src_ob   = (sq_mb_r[SQ_N-1] >> DV_N) >= W2'(sq_root_r[SQ_N-1]);
      assign src_zero = (sq_root_r[SQ_N-1] == '0);
      assign src_side = sq_side_r[SQ_N-1];
    end else begin : g_next
      assign src_vld  = dv_vld_r[i-1];
      assign src_r    = dv_r_r[i-1];
      assign src_ra   = dv_ra_r[i-1];
      assign src_rb   = dv_rb_r[i-1];
      assign src_qa   = dv_qa_r[i-1];
      assign src_qb   = dv_qb_r[i-1];
      assign src_oa   = dv_oa_r[i-1];
      assign src_ob   = dv_ob_r[i-1];
      assign src_zero = dv_zero_r[i-1];
      assign src_side = dv_side_r[i-1];
    end

    assign dsr = W2'(src_r) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[i] <= 1'b0;
      end else begin
        dv_vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (src_vld) begin
        if (src_ra >= dsr) begin
          dv_ra_r[i] <= src_ra - dsr;
          dv_qa_r[i] <= src_qa | (DV_N'(1) << B);
        end else begin
          dv_ra_r[i] <= src_ra;
          dv_qa_r[i] <= src_qa;
        end
        if (src_rb >= dsr) begin
          dv_rb_r[i] <= src_rb - dsr;
          dv_qb_r[i] <= src_qb | (DV_N'(1) << B);
        end else begin
          dv_rb_r[i] <= src_rb;
          dv_qb_r[i] <= src_qb;
        end
        dv_r_r[i]    <= src_r;
        dv_oa_r[i]   <= src_oa;
        dv_ob_r[i]   <= src_ob;
        dv_zero_r[i] <= src_zero;
        dv_side_r[i] <= src_side;
      end
    end
  end

  // Final stage: signs, saturation, and the zero-radius bypass.
  logic       fin_vld_r;
  polar_res_t res_r;
  side_t      ls;

  assign ls = dv_side_r[DV_N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= dv_vld_r[DV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (dv_vld_r[DV_N-1]) begin
      res_r.radius <= dv_r_r[DV_N-1][W-1] ? SMAX : $signed(dv_r_r[DV_N-1]);
      res_r.r_zero <= dv_zero_r[DV_N-1];
      if (dv_zero_r[DV_N-1]) begin
        res_r.vel_r <= ls.v1;
        res_r.vel_t <= ls.v2;
      end else begin
        res_r.vel_r <= apply_sign(ls.neg_a, dv_oa_r[DV_N-1], dv_qa_r[DV_N-1]);
        res_r.vel_t <= apply_sign(ls.neg_b, dv_ob_r[DV_N-1], dv_qb_r[DV_N-1]);
      end
    end
  end

  assign out_vld = fin_vld_r;
  assign out_res = res_r;

endmodule

`default_nettype wire

// ===== src/cylindrical_cartesian_converter_top.sv =====
`default_nettype none

// Cylindrical / Cartesian converter for one particle's position and velocity.
//
// Input channel: a transaction is taken at a rising edge where start is high
// and busy is low. busy is held low: the block is fully pipelined and takes a
// new transaction on every clock.
// Configuration: cfg_wr_en writes cfg_wr_data into the direction register
// (0 = Cartesian to cylindrical, 1 = cylindrical to Cartesian). Each
// transaction latches the direction when it is taken, so write it while idle.
// Result channel: out_valid is high for exactly one cycle per transaction,
// with the six result fields alongside; the receiver cannot stall, so the
// pipeline never holds. Results leave in the order the transactions came in.
// Latency is set by the square root (one root bit per stage) followed by the
// restoring dividers for the velocity projection (one quotient bit per stage);
// the CORDIC and gain path is shorter and is delayed to line up with it.
// Reset is synchronous and active low; it clears the valid bits of every
// stage and returns the direction register to Cartesian to cylindrical.

module cylindrical_cartesian_converter_top
  import ccc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [WORD_BITS-1:0] in_pos_first,
  input  wire logic signed [WORD_BITS-1:0] in_pos_second,
  input  wire logic signed [WORD_BITS-1:0] in_pos_third,
  input  wire logic signed [WORD_BITS-1:0] in_vel_first,
  input  wire logic signed [WORD_BITS-1:0] in_vel_second,
  input  wire logic signed [WORD_BITS-1:0] in_vel_third,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_wr_data,
  output logic                             out_valid,
  output logic signed [WORD_BITS-1:0]      out_pos_first,
  output logic signed [WORD_BITS-1:0]      out_pos_second,
  output logic signed [WORD_BITS-1:0]      out_pos_third,
  output logic signed [WORD_BITS-1:0]      out_vel_first,
  output logic signed [WORD_BITS-1:0]      out_vel_second,
  output logic signed [WORD_BITS-1:0]      out_vel_third
);

  localparam int ALIGN = POLAR_LAT - CORDIC_LAT;

  typedef struct packed {
    logic                        dir;
    logic signed [WORD_BITS-1:0] p3;
    logic signed [WORD_BITS-1:0] v3;
  } side_t;

  logic accept;
  logic dir_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (cfg_wr_en) begin
      dir_r <= cfg_wr_data;
    end
  end

  // Input register: both datapaths start from here.
  logic                        a_vld_r;
  logic                        a_dir_r;
  logic signed [WORD_BITS-1:0] a_p1_r, a_p2_r, a_p3_r, a_v1_r, a_v2_r, a_v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_dir_r <= dir_r;
      a_p1_r  <= in_pos_first;
      a_p2_r  <= in_pos_second;
      a_p3_r  <= in_pos_third;
      a_v1_r  <= in_vel_first;
      a_v2_r  <= in_vel_second;
      a_v3_r  <= in_vel_third;
    end
  end

  // Radius and velocity projection; its valid output marks every result.
  logic       pol_vld;
  polar_res_t pol_res;

  ccc_polar u_polar (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (a_vld_r),
    .in_p1   (a_p1_r),
    .in_p2   (a_p2_r),
    .in_v1   (a_v1_r),
    .in_v2   (a_v2_r),
    .out_vld (pol_vld),
    .out_res (pol_res)
  );

  // Shared CORDIC: vectoring gives phi, rotation gives the Cartesian results.
  cordic_res_t cor_res;

  ccc_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (a_vld_r),
    .in_rot  (a_dir_r),
    .in_p1   (a_p1_r),
    .in_p2   (a_p2_r),
    .in_v1   (a_v1_r),
    .in_v2   (a_v2_r),
    .out_res (cor_res)
  );

  // Delay lines that line the shorter paths up with the polar pipeline.
  cordic_res_t cdly_r [ALIGN];
  side_t       side_r [POLAR_LAT];

  always_ff @(posedge clk) begin
    cdly_r[0] <= cor_res;
    for (int i = 1; i < ALIGN; i++) begin
      cdly_r[i] <= cdly_r[i-1];
    end
    side_r[0] <= '{dir: a_dir_r, p3: a_p3_r, v3: a_v3_r};
    for (int i = 1; i < POLAR_LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  cordic_res_t cd;
  side_t       sd;

  assign cd = cdly_r[ALIGN-1];
  assign sd = side_r[POLAR_LAT-1];

  // Result register: pick the direction's outputs. A zero radius forces phi
  // to zero, since the vectoring CORDIC has no defined angle there.
  logic                        out_valid_r;
  logic signed [WORD_BITS-1:0] o_pos1_r, o_pos2_r, o_pos3_r, o_vel1_r, o_vel2_r, o_vel3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pol_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pol_vld) begin
      o_pos3_r <= sd.p3;
      o_vel3_r <= sd.v3;
      if (sd.dir) begin
        o_pos1_r <= cd.pos_x;
        o_pos2_r <= cd.pos_y;
        o_vel1_r <= cd.vel_x;
        o_vel2_r <= cd.vel_y;
      end else begin
        o_pos1_r <= pol_res.radius;
        o_pos2_r <= pol_res.r_zero ? '0 : cd.angle;
        o_vel1_r <= pol_res.vel_r;
        o_vel2_r <= pol_res.vel_t;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_first  = o_pos1_r;
  assign out_pos_second = o_pos2_r;
  assign out_pos_third  = o_pos3_r;
  assign out_vel_first  = o_vel1_r;
  assign out_vel_second = o_vel2_r;
  assign out_vel_third  = o_vel3_r;

endmodule

`default_nettype wire

// ===== test/cylindrical_cartesian_converter_top_tb.sv =====
`default_nettype none

module cylindrical_cartesian_converter_top_tb;
  import ccc_pkg::*;

  // One particle: index 0..5 is pos_first, pos_second, pos_third,
  // vel_first, vel_second, vel_third.
  typedef logic [5:0][WORD_BITS-1:0] particle_t;

  localparam bit TO_CYL  = 1'b0;
  localparam bit TO_CART = 1'b1;
  // Drain for longer than the result strobe trails the accept edge.
  localparam int DRAIN_CYCLES = 90;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic signed [WORD_BITS-1:0] in_pos_first = '0;
  logic signed [WORD_BITS-1:0] in_pos_second = '0;
  logic signed [WORD_BITS-1:0] in_pos_third = '0;
  logic signed [WORD_BITS-1:0] in_vel_first = '0;
  logic signed [WORD_BITS-1:0] in_vel_second = '0;
  logic signed [WORD_BITS-1:0] in_vel_third = '0;
  logic busy;
  logic out_valid;
  logic signed [WORD_BITS-1:0] out_pos_first, out_pos_second, out_pos_third;
  logic signed [WORD_BITS-1:0] out_vel_first, out_vel_second, out_vel_third;

  cylindrical_cartesian_converter_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_pos_first(in_pos_first),
    .in_pos_second(in_pos_second),
    .in_pos_third(in_pos_third),
    .in_vel_first(in_vel_first),
    .in_vel_second(in_vel_second),
    .in_vel_third(in_vel_third),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_pos_first(out_pos_first),
    .out_pos_second(out_pos_second),
    .out_pos_third(out_pos_third),
    .out_vel_first(out_vel_first),
    .out_vel_second(out_vel_second),
    .out_vel_third(out_vel_third)
  );

  always #5 clk = ~clk;

  // Our own copy of the direction register, updated when we write it.
  bit        direction = TO_CYL;
  // Expected conversions, oldest first.
  particle_t expected_particles [$];
  int        mismatches = 0;
  // When set, the sender never pauses between transactions.
  bit        back_to_back = 1'b0;

  // ---------------------------------------------------------------------
  // Prediction of one conversion.
  // ---------------------------------------------------------------------

  function automatic logic [WORD_BITS-1:0] sat_q16(input longint v);
    logic [WORD_BITS-1:0] res;
    if (v > longint'(SMAX)) begin
      res = SMAX;
    end else if (v < longint'(SMIN)) begin
      res = SMIN;
    end else begin
      res = v[WORD_BITS-1:0];
    end
    return res;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // (a + b) / r, truncated toward zero and saturated; r is nonzero.
  function automatic logic [WORD_BITS-1:0] project_velocity(input longint a, input longint b,
                                                           input longint unsigned r);
    longint unsigned mag, q;
    longint s;
    bit neg;
    logic [WORD_BITS-1:0] res;
    if (a >= 0 && b >= 0) begin
      mag = longint'(unsigned'(a)) + longint'(unsigned'(b));
      neg = 1'b0;
    end else begin
      s = a + b;
      neg = s < 0;
      mag = neg ? unsigned'(-s) : unsigned'(s);
    end
    q = mag / r;
    if (neg) begin
      if (q > 64'h7FFF_FFFF) res = SMIN;
      else res = 32'(-longint'(q));
    end else begin
      if (q > 64'h7FFF_FFFF) res = SMAX;
      else res = q[WORD_BITS-1:0];
    end
    return res;
  endfunction

  function automatic longint phase_of(input longint px, input longint py);
    longint x, y, acc, t, dx, dy, step;
    x = px * (64'sd1 <<< PRESHIFT);
    y = py * (64'sd1 <<< PRESHIFT);
    acc = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = 64'sd1 <<< 30;
      end else begin
        t = x; x = -y; y = t; acc = -(64'sd1 <<< 30);
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      step = longint'(ANGTAB[i]);
      if (y > 0) begin
        x = x + dx; y = y - dy; acc = acc + step;
      end else begin
        x = x - dx; y = y + dy; acc = acc - step;
      end
    end
    return acc;
  endfunction

  // Back to Q16.16, then gain compensation with half-up rounding.
  function automatic logic [WORD_BITS-1:0] unscale(input longint v);
    longint w, g;
    g = longint'(GAIN_Q30);
    w = (v + (64'sd1 <<< (PRESHIFT - 1))) >>> PRESHIFT;
    return sat_q16((w * g + (64'sd1 <<< 29)) >>> 30);
  endfunction

  function automatic particle_t convert_particle(input particle_t in, input bit dir);
    longint p1, p2, v1, v2, a, t, px, py, vx, vy, pdx, pdy, vdx, vdy, quarter, step;
    longint unsigned ax, ay, r;
    particle_t o;
    p1 = longint'($signed(in[0]));
    p2 = longint'($signed(in[1]));
    v1 = longint'($signed(in[3]));
    v2 = longint'($signed(in[4]));
    o[2] = in[2];
    o[5] = in[5];
    if (dir == TO_CYL) begin
      ax = p1 < 0 ? unsigned'(-p1) : unsigned'(p1);
      ay = p2 < 0 ? unsigned'(-p2) : unsigned'(p2);
      r = int_sqrt(ax * ax + ay * ay);
      o[0] = (r > 64'h7FFF_FFFF) ? SMAX : r[WORD_BITS-1:0];
      if (r == 0) begin
        // Zero radius: phi is 0 and the velocity passes unrotated.
        o[1] = '0;
        o[3] = in[3];
        o[4] = in[4];
      end else begin
        t = phase_of(p1, p2);
        o[1] = t[WORD_BITS-1:0];
        o[3] = project_velocity(p1 * v1, p2 * v2, r);
        o[4] = project_velocity(p1 * v2, -(p2 * v1), r);
      end
    end else begin
      quarter = 64'sd1 <<< 30;
      a = p2;
      px = p1 * (64'sd1 <<< PRESHIFT);
      py = 0;
      vx = v1 * (64'sd1 <<< PRESHIFT);
      vy = v2 * (64'sd1 <<< PRESHIFT);
      if (a > quarter) begin
        t = px; px = -py; py = t;
        t = vx; vx = -vy; vy = t;
        a = a - quarter;
      end else if (a < -quarter) begin
        t = px; px = py; py = -t;
        t = vx; vx = vy; vy = -t;
        a = a + quarter;
      end
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        pdx = py >>> k; pdy = px >>> k;
        vdx = vy >>> k; vdy = vx >>> k;
        step = longint'(ANGTAB[k]);
        if (a >= 0) begin
          px = px - pdx; py = py + pdy; vx = vx - vdx; vy = vy + vdy; a = a - step;
        end else begin
          px = px + pdx; py = py - pdy; vx = vx + vdx; vy = vy - vdy; a = a + step;
        end
      end
      o[0] = unscale(px);
      o[1] = unscale(py);
      o[3] = unscale(vx);
      o[4] = unscale(vy);
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking: every strobe is matched against the oldest expectation.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    particle_t got, want;
    if (rst_n && out_valid) begin
      got = {out_vel_third, out_vel_second, out_vel_first,
             out_pos_third, out_pos_second, out_pos_first};
      if (expected_particles.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transaction at %0t: %h", $time, got);
      end else begin
        want = expected_particles.pop_front();
        for (int f = 0; f < 6; f++) begin
          if (got[f] !== want[f]) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("field %0d mismatch at %0t: expected %h, got %h",
                       f, $time, want[f], got[f]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Offers one transaction and records its expectation once accepted. Start is
  // left high unless a pause follows, so bursts run back to back.
  task automatic send_particle(input particle_t p);
    int gap;
    start <= 1'b1;
    in_pos_first <= p[0];
    in_pos_second <= p[1];
    in_pos_third <= p[2];
    in_vel_first <= p[3];
    in_vel_second <= p[4];
    in_vel_third <= p[5];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_particles.push_back(convert_particle(p, direction));
    if (!back_to_back && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets the pipeline empty; the direction is latched per transaction, so
  // configuration writes happen only after it.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (expected_particles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input bit dir);
    drain_pipeline();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= dir;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    direction = dir;
    @(posedge clk);
  endtask

  function automatic logic [WORD_BITS-1:0] random_word();
    logic [WORD_BITS-1:0] w;
    case ($urandom_range(0, 7))
      0: w = SMAX;
      1: w = SMIN;
      2: w = '0;
      3: w = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      4: w = 32'($signed(20'($urandom())));
      5: w = $signed({1'($urandom_range(0, 1)), 31'($urandom())}) >>> $urandom_range(0, 31);
      default: w = $urandom();
    endcase
    return w;
  endfunction

  function automatic particle_t random_particle();
    particle_t p;
    for (int f = 0; f < 6; f++) p[f] = random_word();
    // Now and then put the point exactly on an axis or the origin.
    case ($urandom_range(0, 9))
      0: p[0] = '0;
      1: p[1] = '0;
      2: begin p[0] = '0; p[1] = '0; end
      default: ;
    endcase
    return p;
  endfunction

  function automatic particle_t make_particle(input logic [WORD_BITS-1:0] a,
                                              input logic [WORD_BITS-1:0] b);
    particle_t p;
    p[0] = a;
    p[1] = b;
    p[2] = $urandom();
    p[3] = $urandom();
    p[4] = $urandom();
    p[5] = $urandom();
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Cartesian to cylindrical: origin, axes, quadrants and the extremes.
  task automatic test_cartesian_corners();
    particle_t p;
    write_direction(TO_CYL);
    p = '0;
    send_particle(p);                                  // origin, zero velocity
    send_particle(make_particle('0, '0));              // origin, velocity passes
    send_particle(make_particle(32'h0001_0000, '0));   // positive x axis
    send_particle(make_particle(32'hFFFF_0000, '0));   // negative x axis wraps to -pi
    send_particle(make_particle('0, 32'h0001_0000));   // positive y axis
    send_particle(make_particle('0, 32'hFFFF_0000));   // negative y axis
    send_particle(make_particle(SMIN, SMIN));          // radius saturates
    send_particle(make_particle(SMAX, SMAX));
    send_particle(make_particle(SMIN, SMAX));
    send_particle(make_particle(32'd1, 32'd1));
    p = '1;
    send_particle(p);
    p = {6{SMAX}};
    send_particle(p);                                  // velocity projection saturates
    p = {6{SMIN}};
    send_particle(p);
  endtask

  // Cylindrical to Cartesian: angle extremes, quadrant edges, negative radius.
  task automatic test_cylindrical_corners();
    write_direction(TO_CART);
    send_particle(make_particle(32'h0001_0000, '0));
    send_particle(make_particle(32'h0001_0000, SMAX));
    send_particle(make_particle(32'h0001_0000, SMIN));
    send_particle(make_particle(SMAX, 32'h4000_0000));
    send_particle(make_particle(SMAX, 32'h4000_0001));
    send_particle(make_particle(SMIN, 32'hC000_0000));
    send_particle(make_particle(SMIN, 32'hBFFF_FFFF));
    send_particle(make_particle(32'hFFFF_0000, 32'h2000_0000));  // negative radius
    send_particle(make_particle('0, $urandom()));
    send_particle({SMAX, SMAX, SMAX, SMAX, 32'h6000_0000, SMAX});
    send_particle({SMIN, SMIN, SMIN, SMIN, 32'hA000_0000, SMIN});
  endtask

  // Random particles in one direction; from a third to half way through the
  // burst the sender never pauses, so the pipeline is kept full.
  task automatic test_random_conversions(input bit dir, input int count);
    write_direction(dir);
    for (int n = 0; n < count; n++) begin
      back_to_back = (n >= count / 3) && (n < count / 2);
      send_particle(random_particle());
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cartesian_corners();
    test_cylindrical_corners();
    test_random_conversions(TO_CYL, 320);
    test_random_conversions(TO_CART, 320);
    test_random_conversions(TO_CYL, 300);
    test_random_conversions(TO_CART, 300);
    drain_pipeline();
    if (mismatches == 0 && expected_particles.size() == 0) begin
      $display("cylindrical_cartesian_converter_top verification clean");
    end else begin
      $display("cylindrical_cartesian_converter_top verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake or a result that never arrives.
  initial begin
    #3000000;
    $display("cylindrical_cartesian_converter_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire
